/* rtl/core/afpc_pkg.sv */
// Shared types, constants and the helper function of the FEC profile controller.
`default_nettype none

package afpc_pkg;

  localparam int unsigned PPM_W     = 20;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned COLUMN_W  = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned PROF_W    = 3;
  localparam int unsigned RANK_W    = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [PPM_W-1:0]   PPM_LIMIT        = PPM_W'(1000000);
  localparam logic [PPM_W-1:0]   DEF_HIGH_LOSS    = PPM_W'(150000);
  localparam logic [PPM_W-1:0]   DEF_MEDIUM_LOSS  = PPM_W'(50000);
  localparam logic [PPM_W-1:0]   DEF_LOW_LOSS     = PPM_W'(30000);
  localparam logic [PPM_W-1:0]   DEF_RESIDUAL     = PPM_W'(20000);
  localparam logic [BURST_W-1:0] DEF_BURST        = BURST_W'(6);
  localparam logic [TIME_W-1:0]  DEF_HOLD_MS      = TIME_W'(1000);
  localparam logic [TIME_W-1:0]  DEF_WINDOW_LEN   = TIME_W'(1000);
  localparam logic [COUNT_W-1:0] DEF_WINDOWS      = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] STABLE_MAX       = COUNT_W'(255);

  // Profile codes.
  localparam logic [PROF_W-1:0] PROF_NONE = 3'd0;
  localparam logic [PROF_W-1:0] PROF_RS86 = 3'd1;
  localparam logic [PROF_W-1:0] PROF_D4L8 = 3'd2;
  localparam logic [PROF_W-1:0] PROF_D3L4 = 3'd3;
  localparam logic [PROF_W-1:0] PROF_D4L4 = 3'd4;
  localparam logic [PROF_W-1:0] PROF_D5L4 = 3'd5;
  localparam logic [PROF_W-1:0] PROF_D8L4 = 3'd6;

  localparam int unsigned DEF_START_PROFILE = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LOSS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LOSS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LOSS    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWS     = 8'd7;

  typedef struct packed {
    logic [PPM_W-1:0]   high_loss;
    logic [PPM_W-1:0]   medium_loss;
    logic [PPM_W-1:0]   low_loss;
    logic [PPM_W-1:0]   residual;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  hold_ms;
    logic [TIME_W-1:0]  window_len;
    logic [COUNT_W-1:0] windows;
  } afpc_cfg_t;

  // Worst metrics of the window with the current report folded in.
  typedef struct packed {
    logic [PPM_W-1:0]    loss;
    logic [PPM_W-1:0]    resid;
    logic [BURST_W-1:0]  burst;
    logic [COLUMN_W-1:0] column;
    logic                bad;
  } afpc_win_t;

  typedef struct packed {
    logic [PROF_W-1:0] profile;
    logic              changed;
    logic              status;
  } afpc_res_t;

  // Overhead rank of a profile code; equal ranks mean equal overhead.
  function automatic logic [RANK_W-1:0] overhead_rank(input logic [PROF_W-1:0] p);
    logic [RANK_W-1:0] r;
    case (p)
      PROF_RS86: r = 3'd4;
      PROF_D4L8: r = 3'd3;
      PROF_D3L4: r = 3'd4;
      PROF_D4L4: r = 3'd3;
      PROF_D5L4: r = 3'd2;
      PROF_D8L4: r = 3'd1;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/adaptive_fec_profile_controller.sv */
// Top level of the adaptive FEC profile controller.
`default_nettype none

// The controller takes one link report request per clock cycle while in_stall
// is low. Each request is first captured in an input register; as it leaves
// that register the window accumulator folds it into the worst-of-window
// metrics and, when the request carries the last-report mark, the decision
// logic picks the profile, updates the hold and stability state and loads
// the result register. Only last reports produce a result. The input side
// stalls only when a last report sits in the input register while the
// result register is still full and stalled downstream; ordinary reports
// always drain. Configuration writes are taken every cycle (cfg_ready is
// constant high) and must happen while the block is idle. Time differences
// wrap modulo 2^32.
module adaptive_fec_profile_controller
  import afpc_pkg::*;
#(
  parameter int unsigned START_PROFILE = DEF_START_PROFILE
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PPM_W-1:0]     in_loss_ppm,
  input  wire logic [PPM_W-1:0]     in_residual_ppm,
  input  wire logic [BURST_W-1:0]   in_burst_len,
  input  wire logic [COLUMN_W-1:0]  in_column_losses,
  input  wire logic [TIME_W-1:0]    in_now_ms,
  input  wire logic                 in_last_report,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PROF_W-1:0]         out_chosen_profile,
  output logic                      out_did_change,
  output logic                      out_status,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Configuration registers; the mapping to defaults lives in the decision unit.
  afpc_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_LOSS:   cfg_nxt.high_loss   = cfg_wdata[PPM_W-1:0];
        REG_MEDIUM_LOSS: cfg_nxt.medium_loss = cfg_wdata[PPM_W-1:0];
        REG_LOW_LOSS:    cfg_nxt.low_loss    = cfg_wdata[PPM_W-1:0];
        REG_RESIDUAL:    cfg_nxt.residual    = cfg_wdata[PPM_W-1:0];
        REG_BURST:       cfg_nxt.burst       = cfg_wdata[BURST_W-1:0];
        REG_HOLD_MS:     cfg_nxt.hold_ms     = cfg_wdata[TIME_W-1:0];
        REG_WINDOW_LEN:  cfg_nxt.window_len  = cfg_wdata[TIME_W-1:0];
        REG_WINDOWS:     cfg_nxt.windows     = cfg_wdata[COUNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Input register stage.
  logic                in_valid_r, in_valid_nxt;
  logic [PPM_W-1:0]    loss_r;
  logic [PPM_W-1:0]    resid_r;
  logic [BURST_W-1:0]  burst_r;
  logic [COLUMN_W-1:0] column_r;
  logic [TIME_W-1:0]   now_r;
  logic                last_r;

  // Result register stage.
  logic                out_valid_r, out_valid_nxt;
  afpc_res_t           res_r;
  afpc_res_t           res_c;
  afpc_win_t           win_c;

  logic out_free, proc, in_take, emit;

  // The held request is processed when it makes no result, or when the result
  // register is empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && (!last_r || out_free);
  assign emit     = proc && last_r;
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (proc) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  afpc_acc u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (proc),
    .last          (last_r),
    .loss_ppm      (loss_r),
    .residual_ppm  (resid_r),
    .burst_len     (burst_r),
    .column_losses (column_r),
    .win           (win_c)
  );

  afpc_decide #(
    .START_PROFILE (START_PROFILE)
  ) u_decide (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (emit),
    .cfg    (cfg_r),
    .win    (win_c),
    .now_ms (now_r),
    .res    (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      loss_r   <= in_loss_ppm;
      resid_r  <= in_residual_ppm;
      burst_r  <= in_burst_len;
      column_r <= in_column_losses;
      now_r    <= in_now_ms;
      last_r   <= in_last_report;
    end
    if (emit) begin
      res_r <= res_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_profile = res_r.profile;
  assign out_did_change     = res_r.changed;
  assign out_status         = res_r.status;

`ifndef SYNTHESIS
  // An error window never switches the profile.
  a_status_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> !out_did_change)
    else $error("error result reports a profile change");

  // A last report from a window with a bad metric yields an error result.
  a_bad_window_status: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && win_c.bad) |=> (out_valid && out_status))
    else $error("bad metric window did not report an error");

  // The input side only stalls while a last report waits on a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

/* rtl/core/afpc_acc.sv */
// Window accumulator: keeps the worst metrics and the bad-metric flag of a window.
`default_nettype none

module afpc_acc
  import afpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic                last,
  input  wire logic [PPM_W-1:0]    loss_ppm,
  input  wire logic [PPM_W-1:0]    residual_ppm,
  input  wire logic [BURST_W-1:0]  burst_len,
  input  wire logic [COLUMN_W-1:0] column_losses,
  output afpc_win_t                win
);

  afpc_win_t acc_r;
  afpc_win_t acc_nxt;
  logic      item_bad;

  always_comb begin
    item_bad = (loss_ppm > PPM_LIMIT) || (residual_ppm > PPM_LIMIT);
    win      = acc_r;
    win.bad  = acc_r.bad | item_bad;
    // Out-of-range reports are flagged but never folded into the maxima.
    if (!item_bad) begin
      if (loss_ppm > acc_r.loss)       win.loss   = loss_ppm;
      if (residual_ppm > acc_r.resid)  win.resid  = residual_ppm;
      if (burst_len > acc_r.burst)     win.burst  = burst_len;
      if (column_losses > acc_r.column) win.column = column_losses;
    end
    acc_nxt = acc_r;
    if (fire) begin
      acc_nxt = last ? '0 : win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/afpc_decide.sv */
// Profile decision: target selection, hold time and downgrade stability tracking.
`default_nettype none

module afpc_decide
  import afpc_pkg::*;
#(
  parameter int unsigned START_PROFILE = DEF_START_PROFILE
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire afpc_cfg_t         cfg,
  input  wire afpc_win_t         win,
  input  wire logic [TIME_W-1:0] now_ms,
  output afpc_res_t              res
);

  localparam logic [PROF_W-1:0] INIT_PROF = PROF_W'(START_PROFILE);

  logic [PROF_W-1:0]  active_r, active_nxt;
  logic [PROF_W-1:0]  cand_r, cand_nxt;
  logic [TIME_W-1:0]  change_time_r, change_time_nxt;
  logic [TIME_W-1:0]  window_time_r, window_time_nxt;
  logic [COUNT_W-1:0] stable_r, stable_nxt;

  logic [PPM_W-1:0]   thr_high, thr_med, thr_low, thr_resid;
  logic [BURST_W-1:0] thr_burst;
  logic [TIME_W-1:0]  thr_hold, thr_window;
  logic [COUNT_W-1:0] thr_windows;
  logic [PROF_W-1:0]  target;
  logic               col_pattern, burst_hit, pattern, switch_now, changed;

  always_comb begin
    // A zero register selects its default.
    thr_high    = (cfg.high_loss == '0)   ? DEF_HIGH_LOSS   : cfg.high_loss;
    thr_med     = (cfg.medium_loss == '0) ? DEF_MEDIUM_LOSS : cfg.medium_loss;
    thr_low     = (cfg.low_loss == '0)    ? DEF_LOW_LOSS    : cfg.low_loss;
    thr_resid   = (cfg.residual == '0)    ? DEF_RESIDUAL    : cfg.residual;
    thr_burst   = (cfg.burst == '0)       ? DEF_BURST       : cfg.burst;
    thr_hold    = (cfg.hold_ms == '0)     ? DEF_HOLD_MS     : cfg.hold_ms;
    thr_window  = (cfg.window_len == '0)  ? DEF_WINDOW_LEN  : cfg.window_len;
    thr_windows = (cfg.windows == '0)     ? DEF_WINDOWS     : cfg.windows;

    col_pattern = (win.column != '0) || (win.resid >= thr_resid);
    burst_hit   = win.burst >= thr_burst;
    pattern     = col_pattern || burst_hit;

    if (col_pattern)                target = PROF_RS86;
    else if (burst_hit)             target = PROF_D4L8;
    else if (win.loss >= thr_high)  target = PROF_D3L4;
    else if (win.loss >= thr_med)   target = PROF_D4L4;
    else if (win.loss >= thr_low)   target = PROF_D5L4;
    else                            target = PROF_D8L4;

    active_nxt      = active_r;
    cand_nxt        = cand_r;
    change_time_nxt = change_time_r;
    window_time_nxt = window_time_r;
    stable_nxt      = stable_r;
    switch_now      = 1'b0;

    if (fire && !win.bad) begin
      if (target == active_r) begin
        stable_nxt = '0;
        cand_nxt   = target;
      end else if ((now_ms - change_time_r) >= thr_hold) begin
        if (pattern || (overhead_rank(target) > overhead_rank(active_r))) begin
          switch_now = 1'b1;
        end else if ((now_ms - window_time_r) >= thr_window) begin
          window_time_nxt = now_ms;
          if (cand_r != target) begin
            cand_nxt   = target;
            stable_nxt = COUNT_W'(1);
          end else if (stable_r < STABLE_MAX) begin
            stable_nxt = stable_r + COUNT_W'(1);
          end
          if (stable_nxt >= thr_windows) begin
            switch_now = 1'b1;
          end
        end
      end
      if (switch_now) begin
        active_nxt      = target;
        cand_nxt        = target;
        change_time_nxt = now_ms;
        window_time_nxt = now_ms;
        stable_nxt      = '0;
      end
    end

    changed     = switch_now;
    res.profile = active_nxt;
    res.changed = changed;
    res.status  = win.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= INIT_PROF;
      cand_r        <= INIT_PROF;
      change_time_r <= '0;
      window_time_r <= '0;
      stable_r      <= '0;
    end else begin
      active_r      <= active_nxt;
      cand_r        <= cand_nxt;
      change_time_r <= change_time_nxt;
      window_time_r <= window_time_nxt;
      stable_r      <= stable_nxt;
    end
  end

endmodule

`default_nettype wire

/* test/adaptive_fec_profile_controller_tb.sv */
// Self-checking testbench of the adaptive FEC profile controller against a predictor.
module adaptive_fec_profile_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afpc_pkg::*;

  // Run control. The limit is far above the slowest legal run: about 2000
  // requests with random sender gaps, a receiver that stalls most of the
  // time in its heavy phases, and one long hold-off.
  localparam int unsigned LIMIT_CYCLES       = 500000;
  localparam int unsigned SETTLE_CYCLES      = 8;
  localparam int unsigned LONG_HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AFTER_RESULTS = 200;
  localparam int unsigned MAX_PRINTED        = 100;

  // An index outside the register map. Its low three bits select the high
  // loss register, so a decoder that drops the upper index bits shows up.
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_MAP = 8'd200;

  // One link report as it travels on the input channel.
  typedef struct packed {
    logic [PPM_W-1:0]    loss_ppm;
    logic [PPM_W-1:0]    residual_ppm;
    logic [BURST_W-1:0]  burst_len;
    logic [COLUMN_W-1:0] column_losses;
    logic [TIME_W-1:0]   now_ms;
    logic                last_report;
  } report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [PPM_W-1:0]     in_loss_ppm      = '0;
  logic [PPM_W-1:0]     in_residual_ppm  = '0;
  logic [BURST_W-1:0]   in_burst_len     = '0;
  logic [COLUMN_W-1:0]  in_column_losses = '0;
  logic [TIME_W-1:0]    in_now_ms        = '0;
  logic                 in_last_report   = 1'b0;

  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic [PROF_W-1:0]    out_chosen_profile;
  logic                 out_did_change;
  logic                 out_status;

  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata        = '0;

  adaptive_fec_profile_controller u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_loss_ppm        (in_loss_ppm),
    .in_residual_ppm    (in_residual_ppm),
    .in_burst_len       (in_burst_len),
    .in_column_losses   (in_column_losses),
    .in_now_ms          (in_now_ms),
    .in_last_report     (in_last_report),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chosen_profile (out_chosen_profile),
    .out_did_change     (out_did_change),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the configuration as written through the
  // register port and the decision state of the block, and it is advanced
  // once for every request that the block accepts.
  // ---------------------------------------------------------------------------
  afpc_cfg_t          model_cfg      = '0;
  logic [PROF_W-1:0]  cur_profile    = PROF_W'(DEF_START_PROFILE);
  logic [PROF_W-1:0]  lower_target   = PROF_W'(DEF_START_PROFILE);
  logic [TIME_W-1:0]  changed_at     = '0;
  logic [TIME_W-1:0]  window_at      = '0;
  logic [COUNT_W-1:0] stable_windows = '0;
  logic [PPM_W-1:0]   win_loss       = '0;
  logic [PPM_W-1:0]   win_resid      = '0;
  logic [BURST_W-1:0] win_burst      = '0;
  logic [COLUMN_W-1:0] win_column    = '0;
  logic               win_bad        = 1'b0;

  afpc_res_t   expected_decisions[$];
  report_t     pending_reports[$];

  int unsigned reports_queued   = 0;
  int unsigned reports_accepted = 0;
  int unsigned results_seen     = 0;
  int unsigned mismatch_count   = 0;
  int unsigned cycle_count      = 0;
  logic [TIME_W-1:0] stim_clock = '0;

  // Overhead of a profile; equal values mean equal overhead. Codes outside
  // the profile list carry no overhead.
  function automatic int unsigned profile_weight(input logic [PROF_W-1:0] p);
    case (p)
      PROF_RS86, PROF_D3L4: return 4;
      PROF_D4L8, PROF_D4L4: return 3;
      PROF_D5L4:            return 2;
      PROF_D8L4:            return 1;
      default:              return 0;
    endcase
  endfunction

  function automatic void clear_window();
    win_loss   = '0;
    win_resid  = '0;
    win_burst  = '0;
    win_column = '0;
    win_bad    = 1'b0;
  endfunction

  function automatic void adopt_profile(input logic [PROF_W-1:0] p,
                                        input logic [TIME_W-1:0] t);
    cur_profile    = p;
    lower_target   = p;
    changed_at     = t;
    window_at      = t;
    stable_windows = '0;
  endfunction

  // Folds one accepted report into the window and, on the last report of
  // the window, works out the decision that the block must deliver.
  task automatic fold_report(input report_t r);
    logic [PPM_W-1:0]   resid_lim, high_lim, mid_lim, low_lim;
    logic [BURST_W-1:0] burst_lim;
    logic [TIME_W-1:0]  hold_lim, window_lim, since_change, since_window;
    logic [COUNT_W-1:0] lower_after;
    logic [PROF_W-1:0]  target;
    logic               forced, switched;
    afpc_res_t          res;

    // Out-of-range metrics only poison the window; they are not folded in.
    if (r.loss_ppm > PPM_LIMIT || r.residual_ppm > PPM_LIMIT) begin
      win_bad = 1'b1;
    end else begin
      if (r.loss_ppm > win_loss) win_loss = r.loss_ppm;
      if (r.residual_ppm > win_resid) win_resid = r.residual_ppm;
      if (r.burst_len > win_burst) win_burst = r.burst_len;
      if (r.column_losses > win_column) win_column = r.column_losses;
    end
    if (!r.last_report) return;

    if (win_bad) begin
      res.profile = cur_profile;
      res.changed = 1'b0;
      res.status  = 1'b1;
      expected_decisions.push_back(res);
      clear_window();
      return;
    end

    // A register value of zero selects the built-in default.
    resid_lim   = (model_cfg.residual == '0)    ? DEF_RESIDUAL    : model_cfg.residual;
    high_lim    = (model_cfg.high_loss == '0)   ? DEF_HIGH_LOSS   : model_cfg.high_loss;
    mid_lim     = (model_cfg.medium_loss == '0) ? DEF_MEDIUM_LOSS : model_cfg.medium_loss;
    low_lim     = (model_cfg.low_loss == '0)    ? DEF_LOW_LOSS    : model_cfg.low_loss;
    burst_lim   = (model_cfg.burst == '0)       ? DEF_BURST       : model_cfg.burst;
    hold_lim    = (model_cfg.hold_ms == '0)     ? DEF_HOLD_MS     : model_cfg.hold_ms;
    window_lim  = (model_cfg.window_len == '0)  ? DEF_WINDOW_LEN  : model_cfg.window_len;
    lower_after = (model_cfg.windows == '0)     ? DEF_WINDOWS     : model_cfg.windows;

    forced = (win_column != '0) || (win_resid >= resid_lim);
    if (forced)                      target = PROF_RS86;
    else if (win_burst >= burst_lim) target = PROF_D4L8;
    else if (win_loss >= high_lim)   target = PROF_D3L4;
    else if (win_loss >= mid_lim)    target = PROF_D4L4;
    else if (win_loss >= low_lim)    target = PROF_D5L4;
    else                             target = PROF_D8L4;
    // Burst patterns also bypass the stability rule, even though the
    // interleaved profile may carry less overhead than the current one.
    forced = forced || (win_burst >= burst_lim);
    clear_window();

    // Time differences wrap at the width of the millisecond clock.
    since_change = r.now_ms - changed_at;
    since_window = r.now_ms - window_at;
    switched     = 1'b0;
    if (target == cur_profile) begin
      stable_windows = '0;
      lower_target   = target;
    end else if (since_change >= hold_lim) begin
      if (forced || profile_weight(target) > profile_weight(cur_profile)) begin
        adopt_profile(target, r.now_ms);
        switched = 1'b1;
      end else if (since_window >= window_lim) begin
        window_at = r.now_ms;
        if (lower_target != target) begin
          lower_target   = target;
          stable_windows = COUNT_W'(1);
        end else if (stable_windows < STABLE_MAX) begin
          stable_windows = stable_windows + 1'b1;
        end
        if (stable_windows >= lower_after) begin
          adopt_profile(target, r.now_ms);
          switched = 1'b1;
        end
      end
    end

    res.profile = cur_profile;
    res.changed = switched;
    res.status  = 1'b0;
    expected_decisions.push_back(res);
  endtask

  // Only the first hundred mismatches are printed; all of them are counted.
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatch_count < MAX_PRINTED)
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver. Requests come from the pending queue in bursts of random length
  // with random gaps between bursts. A request stays on the wires, unchanged,
  // until an edge at which in_stall is low; the predictor sees it at exactly
  // that edge.
  // ---------------------------------------------------------------------------
  report_t     on_wire;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_report(on_wire);
        reports_accepted++;
      end
      // The wires are free when nothing is offered or the offer was just taken.
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reports.size() != 0) begin
          on_wire = pending_reports.pop_front();
          in_valid         <= 1'b1;
          in_loss_ppm      <= on_wire.loss_ppm;
          in_residual_ppm  <= on_wire.residual_ppm;
          in_burst_len     <= on_wire.burst_len;
          in_column_losses <= on_wire.column_losses;
          in_now_ms        <= on_wire.now_ms;
          in_last_report   <= on_wire.last_report;
          if (burst_left <= 1) begin
            // One burst in four runs straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result taken from the block is compared with the oldest
  // prediction. The receiver stall follows its own pattern: it switches
  // between never stalling, light and heavy random stalling and strict
  // alternation. Once, after a number of results, it holds off for a long
  // stretch so that results back up and the block has to stall its input.
  // ---------------------------------------------------------------------------
  afpc_res_t   want;
  int unsigned stall_style    = 0;
  int unsigned style_left     = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_decisions.size() == 0) begin
          flag_mismatch("result with no request pending, chosen_profile",
                        out_chosen_profile, 0);
        end else begin
          want = expected_decisions.pop_front();
          if (out_chosen_profile !== want.profile)
            flag_mismatch("chosen_profile", out_chosen_profile, want.profile);
          if (out_did_change !== want.changed)
            flag_mismatch("did_change", out_did_change, want.changed);
          if (out_status !== want.status)
            flag_mismatch("status", out_status, want.status);
        end
      end

      if (long_hold_left != 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 3);
          style_left  = $urandom_range(32, 128);
        end else begin
          style_left--;
        end
        case (stall_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_report(input logic [PPM_W-1:0] loss, input logic [PPM_W-1:0] resid,
                              input logic [BURST_W-1:0] burst,
                              input logic [COLUMN_W-1:0] column,
                              input logic [TIME_W-1:0] now, input logic last);
    report_t r;
    r.loss_ppm      = loss;
    r.residual_ppm  = resid;
    r.burst_len     = burst;
    r.column_losses = column;
    r.now_ms        = now;
    r.last_report   = last;
    pending_reports.push_back(r);
    reports_queued++;
  endtask

  // Loss values cluster around the default levels, with a small share out
  // of range so that some windows are rejected.
  function automatic logic [PPM_W-1:0] pick_loss();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return PPM_LIMIT;
      2, 3:    return PPM_W'($urandom_range(0, 45000));
      4:       return PPM_W'($urandom_range(140000, 160000));
      5:       return PPM_W'($urandom_range(25000, 60000));
      6:       return ($urandom_range(0, 3) == 0) ? PPM_W'($urandom_range(1000001, 1048575))
                                                   : PPM_W'($urandom_range(0, 1000000));
      default: return PPM_W'($urandom_range(0, 300000));
    endcase
  endfunction

  function automatic logic [PPM_W-1:0] pick_residual();
    case ($urandom_range(0, 29))
      0:       return PPM_W'($urandom_range(1000001, 1048575));
      1, 2, 3: return PPM_W'($urandom_range(0, 1000000));
      4, 5, 6: return PPM_W'($urandom_range(15000, 25000));
      default: return PPM_W'($urandom_range(0, 15000));
    endcase
  endfunction

  function automatic logic [BURST_W-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return BURST_W'($urandom_range(0, 8));
      6, 7, 8:          return BURST_W'($urandom_range(0, 40));
      default:          return BURST_W'($urandom);
    endcase
  endfunction

  // Column losses are rare on a healthy link, so most reports carry none.
  function automatic logic [COLUMN_W-1:0] pick_column();
    case ($urandom_range(0, 19))
      15, 16, 17: return COLUMN_W'($urandom_range(1, 3));
      18, 19:     return COLUMN_W'($urandom);
      default:    return '0;
    endcase
  endfunction

  // One well-formed window: a few reports, the last one closing it. The
  // clock moves forward by a random step, and now and then jumps anywhere,
  // which also exercises the wrap of the time differences. Reports that do
  // not close the window carry a random time stamp that must be ignored.
  task automatic queue_window(input logic [TIME_W-1:0] advance_max);
    int unsigned n, k;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
    if ($urandom_range(0, 29) == 0) stim_clock = $urandom;
    else stim_clock = stim_clock + $urandom_range(0, advance_max);
    for (k = 1; k <= n; k++) begin
      queue_report(pick_loss(), pick_residual(), pick_burst(), pick_column(),
                   (k == n) ? stim_clock : TIME_W'($urandom), k == n);
    end
  endtask

  task automatic queue_random_windows(input int unsigned count,
                                      input logic [TIME_W-1:0] advance_max);
    int unsigned goal;
    goal = reports_queued + count;
    while (reports_queued < goal) queue_window(advance_max);
  endtask

  // Writes one register and mirrors it in the predictor at the edge where
  // the block takes it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HIGH_LOSS:   model_cfg.high_loss   = data[PPM_W-1:0];
      REG_MEDIUM_LOSS: model_cfg.medium_loss = data[PPM_W-1:0];
      REG_LOW_LOSS:    model_cfg.low_loss    = data[PPM_W-1:0];
      REG_RESIDUAL:    model_cfg.residual    = data[PPM_W-1:0];
      REG_BURST:       model_cfg.burst       = data[BURST_W-1:0];
      REG_HOLD_MS:     model_cfg.hold_ms     = data[TIME_W-1:0];
      REG_WINDOW_LEN:  model_cfg.window_len  = data[TIME_W-1:0];
      REG_WINDOWS:     model_cfg.windows     = data[COUNT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_all(input logic [31:0] high, input logic [31:0] mid,
                               input logic [31:0] low, input logic [31:0] resid,
                               input logic [31:0] burst, input logic [31:0] hold,
                               input logic [31:0] window, input logic [31:0] windows);
    write_register(REG_HIGH_LOSS, high);
    write_register(REG_MEDIUM_LOSS, mid);
    write_register(REG_LOW_LOSS, low);
    write_register(REG_RESIDUAL, resid);
    write_register(REG_BURST, burst);
    write_register(REG_HOLD_MS, hold);
    write_register(REG_WINDOW_LEN, window);
    write_register(REG_WINDOWS, windows);
  endtask

  // A quarter of the random settings fall back to the defaults.
  function automatic logic [31:0] rand_level(input int unsigned top);
    return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, top));
  endfunction

  task automatic configure_random();
    configure_all(rand_level(400000), rand_level(200000), rand_level(100000),
                  rand_level(60000), rand_level(20), rand_level(300),
                  rand_level(300), rand_level(6));
  endtask

  // Waits until every queued request has been taken and every predicted
  // result has come back, then lets the pipeline drain. A report that does
  // not close a window leaves no result behind, so the pause covers the
  // time that such a report still spends inside the block.
  task automatic wait_until_idle();
    while (reports_accepted != reports_queued || expected_decisions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, all registers at reset so every default applies. The
    // block starts on the lightest XOR profile with the change time at zero.
    // A time stamp on a report that does not close the window is ignored.
    queue_report('0, '0, '0, '0, 32'hFFFF_FFFF, 1'b0);
    // Clean window with the target equal to the active profile.
    queue_report('0, '0, '0, '0, 32'd500, 1'b1);
    // Loss exactly at the range limit is still valid: raise to the strongest
    // XOR profile once the hold time is over.
    queue_report(PPM_LIMIT, '0, '0, '0, 32'd1500, 1'b1);
    // Loss one above the limit spoils the window even though the closing
    // report is clean.
    queue_report(PPM_LIMIT + 1'b1, '0, '0, '0, 32'd2000, 1'b0);
    queue_report('0, '0, '0, '0, 32'd3000, 1'b1);
    // Residual at the largest field value is out of range too.
    queue_report('0, 20'hFFFFF, '0, '0, 32'd3200, 1'b1);
    // A single same-column loss forces Reed-Solomon.
    queue_report('0, '0, '0, 16'd1, 32'd5000, 1'b1);
    // A burst pattern inside the hold time does not switch.
    queue_report('0, '0, 16'hFFFF, '0, 32'd5500, 1'b1);
    // A burst at the default level switches to deep interleave once the hold
    // time has passed, although that lowers the overhead.
    queue_report('0, '0, 16'd6, '0, 32'd6500, 1'b1);
    // Residual at the default level forces Reed-Solomon again.
    queue_report('0, 20'd20000, '0, '0, 32'd7600, 1'b1);
    // Three clean windows a window time apart lower to the lightest profile.
    queue_report('0, '0, '0, '0, 32'd8700, 1'b1);
    queue_report('0, '0, '0, '0, 32'd9800, 1'b1);
    queue_report('0, '0, '0, '0, 32'd10900, 1'b1);
    // Worst-of-window across several reports.
    queue_report(20'd40000, '0, 16'd3, '0, 32'h5555_5555, 1'b0);
    queue_report('0, 20'd19999, 16'd5, '0, 32'hAAAA_AAAA, 1'b0);
    queue_report('0, '0, '0, '0, 32'd12000, 1'b1);
    // Medium loss near the top of the clock, then across the wrap.
    queue_report(20'd50000, '0, '0, '0, 32'hFFFF_FF00, 1'b1);
    queue_report(20'd30000, '0, '0, '0, 32'h0000_0300, 1'b1);
    queue_report(20'd149999, '0, '0, '0, 32'h0000_0310, 1'b1);
    // Every field at its maximum, out of range, then a closing report whose
    // own metrics are valid.
    queue_report(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b0);
    queue_report('0, PPM_LIMIT, '0, '0, 32'h0000_0800, 1'b1);
    queue_report('0, PPM_LIMIT, '0, '0, 32'h0000_0900, 1'b1);
    stim_clock = 32'h0000_0900;
    wait_until_idle();

    // Random thresholds with short hold and window times, so both raises and
    // lowering sequences happen often.
    configure_random();
    queue_random_windows(500, 32'd400);
    wait_until_idle();

    // Every register at its largest value. The 20-bit levels are written
    // with junk in the upper bits, which the block must drop.
    configure_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random_windows(250, 32'hFFFF_FFFF);
    wait_until_idle();

    // Smallest non-default settings, and a write outside the register map
    // that must change nothing.
    configure_all(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    write_register(REG_BEYOND_MAP, 32'd0);
    queue_random_windows(350, 32'd3);
    wait_until_idle();

    // The longest stability run: raise once, then clean windows, each at least
    // one window time apart, until the block lowers after 255 of them.
    configure_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd255);
    stim_clock = stim_clock + 32'd5;
    queue_report(PPM_LIMIT, '0, '0, '0, stim_clock, 1'b1);
    for (k = 0; k < 258; k++) begin
      stim_clock = stim_clock + $urandom_range(1, 3);
      queue_report(PPM_W'($urandom_range(0, 29999)), PPM_W'($urandom_range(0, 19999)),
                   BURST_W'($urandom_range(0, 5)), '0, stim_clock, 1'b1);
    end
    queue_random_windows(40, 32'd10);
    wait_until_idle();

    // A second random setting with slower time steps.
    configure_random();
    queue_random_windows(450, 32'd2000);
    wait_until_idle();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
